>>> hdl/deq_pkg.sv
// Shared types and constants for the double-ended queue with order reversal.
package deq_pkg;

   localparam int VALUE_W = 32;
   localparam int COUNT_W = 11;

   // Depth of the command queue between front and back.
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

   // Request codes as they arrive on the input channel.
   typedef enum logic [1:0] {
      REQ_INS_FRONT = 2'd0,
      REQ_INS_BACK  = 2'd1,
      REQ_REM_FRONT = 2'd2,
      REQ_REVERSE   = 2'd3
   } req_code_type;

   // Operations on the physical ends of the ring store.
   typedef enum logic [2:0] {
      OP_PUSH_LOW  = 3'd0,
      OP_PUSH_HIGH = 3'd1,
      OP_POP_LOW   = 3'd2,
      OP_POP_HIGH  = 3'd3,
      OP_NOP       = 3'd4
   } op_type;

   typedef struct packed {
      op_type                    op;
      logic signed [VALUE_W-1:0] value;
   } cmd_type;

   typedef struct packed {
      logic                      ok;
      logic signed [VALUE_W-1:0] removed_value;
      logic [COUNT_W-1:0]        count;
   } rsp_type;

   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_READ = 1'b1
   } back_state_type;

endpackage

>>> hdl/deq_front.sv
// Front part: accepts requests, tracks the order flag and maps each request to a physical end.
module deq_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   input  logic [1:0]                         req_type,
   input  logic signed [deq_pkg::VALUE_W-1:0] req_value,
   input  logic                               cmd_ready,
   output logic                               cmd_valid,
   output deq_pkg::cmd_type                   cmd
);

   logic reversed_ff;
   logic reversed_in;
   logic accept;

   assign accept    = push && cmd_ready;
   assign cmd_valid = push;

   always_comb begin
      reversed_in = reversed_ff;
      cmd.value   = req_value;
      cmd.op      = deq_pkg::OP_NOP;
      unique case (deq_pkg::req_code_type'(req_type))
         deq_pkg::REQ_INS_FRONT: begin
            cmd.op = reversed_ff ? deq_pkg::OP_PUSH_HIGH : deq_pkg::OP_PUSH_LOW;
         end
         deq_pkg::REQ_INS_BACK: begin
            cmd.op = reversed_ff ? deq_pkg::OP_PUSH_LOW : deq_pkg::OP_PUSH_HIGH;
         end
         deq_pkg::REQ_REM_FRONT: begin
            cmd.op = reversed_ff ? deq_pkg::OP_POP_HIGH : deq_pkg::OP_POP_LOW;
         end
         deq_pkg::REQ_REVERSE: begin
            cmd.op = deq_pkg::OP_NOP;
            if (accept) begin
               reversed_in = !reversed_ff;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reversed_ff <= 1'b0;
      end else begin
         reversed_ff <= reversed_in;
      end
   end

endmodule

>>> hdl/deq_cmd_fifo.sv
// Short command queue that decouples the front part from the back part.
module deq_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   input  deq_pkg::cmd_type wr_cmd,
   output logic             wr_ready,
   output logic             rd_valid,
   output deq_pkg::cmd_type rd_cmd,
   input  logic             rd_take
);

   deq_pkg::cmd_type               entry_ff [deq_pkg::CMDQ_DEPTH];
   logic [deq_pkg::CMDQ_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [deq_pkg::CMDQ_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [deq_pkg::CMDQ_CW-1:0]    fill_ff, fill_in;
   logic                           do_wr, do_rd;

   assign wr_ready = fill_ff != deq_pkg::CMDQ_CW'(deq_pkg::CMDQ_DEPTH);
   assign rd_valid = fill_ff != '0;
   assign rd_cmd   = entry_ff[rd_ptr_ff];
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_take && rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == deq_pkg::CMDQ_AW'(deq_pkg::CMDQ_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == deq_pkg::CMDQ_AW'(deq_pkg::CMDQ_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      priority if (do_wr && !do_rd) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         fill_in = fill_ff - 1'b1;
      end else begin
         fill_in = fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

>>> hdl/deq_back.sv
// Back part: ring store, end positions, fill count and the result register.
module deq_back #(
   parameter int DEPTH = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  deq_pkg::cmd_type cmd,
   output logic             cmd_take,
   input  logic             rsp_pop,
   output logic             rsp_valid,
   output deq_pkg::rsp_type rsp
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic signed [deq_pkg::VALUE_W-1:0] mem [DEPTH];
   logic signed [deq_pkg::VALUE_W-1:0] rdata_ff;

   deq_pkg::back_state_type state_ff, state_in;
   logic [AW-1:0]    front_ff, front_in;
   logic [AW-1:0]    back_ff, back_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   deq_pkg::rsp_type rsp_ff, rsp_in;

   logic             out_free, has_room, has_item;
   logic             wr_en, rd_en, load, start_read;
   logic [AW-1:0]    wr_addr, rd_addr;
   logic [CW+deq_pkg::COUNT_W-1:0] count_ext;

   function automatic logic [AW-1:0] pos_up(input logic [AW-1:0] p);
      pos_up = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [AW-1:0] pos_down(input logic [AW-1:0] p);
      pos_down = (p == '0) ? AW'(DEPTH - 1) : p - 1'b1;
   endfunction

   assign out_free  = !rsp_valid_ff || rsp_pop;
   assign has_room  = count_ff != CW'(DEPTH);
   assign has_item  = count_ff != '0;
   assign count_ext = {{deq_pkg::COUNT_W{1'b0}}, count_in};
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         deq_pkg::BK_IDLE: begin
            if (start_read) begin
               state_in = deq_pkg::BK_READ;
            end
         end
         deq_pkg::BK_READ: begin
            state_in = deq_pkg::BK_IDLE;
         end
      endcase
   end

   // Datapath control and result formation.
   always_comb begin
      cmd_take            = 1'b0;
      start_read          = 1'b0;
      wr_en               = 1'b0;
      rd_en               = 1'b0;
      wr_addr             = back_ff;
      rd_addr             = front_ff;
      front_in            = front_ff;
      back_in             = back_ff;
      count_in            = count_ff;
      load                = 1'b0;
      rsp_in.ok           = 1'b0;
      rsp_in.removed_value = '0;
      unique case (state_ff)
         deq_pkg::BK_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_take = 1'b1;
               unique case (cmd.op)
                  deq_pkg::OP_PUSH_LOW: begin
                     load = 1'b1;
                     if (has_room) begin
                        front_in  = pos_down(front_ff);
                        wr_en     = 1'b1;
                        wr_addr   = front_in;
                        count_in  = count_ff + 1'b1;
                        rsp_in.ok = 1'b1;
                     end
                  end
                  deq_pkg::OP_PUSH_HIGH: begin
                     load = 1'b1;
                     if (has_room) begin
                        wr_en     = 1'b1;
                        wr_addr   = back_ff;
                        back_in   = pos_up(back_ff);
                        count_in  = count_ff + 1'b1;
                        rsp_in.ok = 1'b1;
                     end
                  end
                  deq_pkg::OP_POP_LOW: begin
                     if (has_item) begin
                        rd_en      = 1'b1;
                        rd_addr    = front_ff;
                        front_in   = pos_up(front_ff);
                        count_in   = count_ff - 1'b1;
                        start_read = 1'b1;
                     end else begin
                        load = 1'b1;
                     end
                  end
                  deq_pkg::OP_POP_HIGH: begin
                     if (has_item) begin
                        rd_en      = 1'b1;
                        back_in    = pos_down(back_ff);
                        rd_addr    = back_in;
                        count_in   = count_ff - 1'b1;
                        start_read = 1'b1;
                     end else begin
                        load = 1'b1;
                     end
                  end
                  deq_pkg::OP_NOP: begin
                     load      = 1'b1;
                     rsp_in.ok = 1'b1;
                  end
                  default: begin
                     load = 1'b1;
                  end
               endcase
            end
         end
         deq_pkg::BK_READ: begin
            load                 = 1'b1;
            rsp_in.ok            = 1'b1;
            rsp_in.removed_value = rdata_ff;
         end
      endcase
      rsp_in.count = count_ext[deq_pkg::COUNT_W-1:0];
   end

   always_comb begin
      priority if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= deq_pkg::BK_IDLE;
         front_ff     <= '0;
         back_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         back_ff      <= back_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   // Ring store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= cmd.value;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

endmodule

>>> hdl/double_ended_queue_with_reverse.sv
// Top level of the bounded double-ended queue with constant-time order reversal.
//
// This block holds up to DEPTH signed 32-bit values in a ring store and serves
// four requests: insert at the front, insert at the back, remove the front
// value, and reverse the order. Every accepted request yields exactly one
// result transfer carrying a success flag, the removed value (zero unless a
// remove succeeded) and the number of stored values after the request. An
// insert into a full store and a remove from an empty store fail and leave the
// contents unchanged; reversal always succeeds and moves no data, because only
// an order flag is toggled. Requests enter through a two-entry command queue,
// so the input side takes up to two more transfers while a result waits to be
// popped. Inserts, failed removes and reversals load their result in the idle
// state of the back part; a successful remove first passes the read state, set
// by the registered read port of the ring store. The store is not cleared after
// reset, and no clearing pass is needed since only occupied slots are ever read.
module double_ended_queue_with_reverse #(
   parameter int DEPTH = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request side.
   input  logic                               push,
   output logic                               full,
   input  logic [1:0]                         req_type,
   input  logic signed [deq_pkg::VALUE_W-1:0] req_value,
   // Result side.
   output logic                               empty,
   input  logic                               pop,
   output logic                               rsp_ok,
   output logic signed [deq_pkg::VALUE_W-1:0] rsp_removed_value,
   output logic [deq_pkg::COUNT_W-1:0]        rsp_count
);

   logic             front_valid;
   deq_pkg::cmd_type front_cmd;
   logic             q_ready;
   logic             q_valid;
   deq_pkg::cmd_type q_cmd;
   logic             q_take;
   logic             rsp_valid;
   deq_pkg::rsp_type rsp;

   // The front part resolves the logical end of every request against the
   // current order flag, so commands in the queue already name a physical end.
   deq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req_type  (req_type),
      .req_value (req_value),
      .cmd_ready (q_ready),
      .cmd_valid (front_valid),
      .cmd       (front_cmd)
   );

   deq_cmd_fifo u_cmdq (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (front_valid),
      .wr_cmd   (front_cmd),
      .wr_ready (q_ready),
      .rd_valid (q_valid),
      .rd_cmd   (q_cmd),
      .rd_take  (q_take)
   );

   // The back part owns the store and positions and holds one result.
   deq_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd       (q_cmd),
      .cmd_take  (q_take),
      .rsp_pop   (pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign full              = !q_ready;
   assign empty             = !rsp_valid;
   assign rsp_ok            = rsp.ok;
   assign rsp_removed_value = rsp.removed_value;
   assign rsp_count         = rsp.count;

endmodule

>>> hdl/deq_checker.sv
// Port-level checks for the double-ended queue, attached to the top level by bind.
module deq_checker #(
   parameter int DEPTH = 1024
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               full,
   input logic                               empty,
   input logic                               pop,
   input logic                               rsp_ok,
   input logic signed [deq_pkg::VALUE_W-1:0] rsp_removed_value,
   input logic [deq_pkg::COUNT_W-1:0]        rsp_count
);

   // Reset leaves no result and room for requests.
   assert property (@(posedge clock) reset |=> empty && !full)
      else $error("queue not idle after reset");

   // A result that waits is held until it is transferred.
   assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_ok) && $stable(rsp_removed_value)
      && $stable(rsp_count))
      else $error("waiting result changed");

   // A failed request never reports a removed value.
   assert property (@(posedge clock) disable iff (reset)
      !empty && !rsp_ok |-> rsp_removed_value == '0)
      else $error("failed request carries a value");

   // The reported count never exceeds the capacity; the check is skipped for DEPTH above 2047.
   assert property (@(posedge clock) disable iff (reset)
      !empty |-> (DEPTH > 2047) || (32'(rsp_count) <= DEPTH))
      else $error("count above capacity");

endmodule

bind double_ended_queue_with_reverse deq_checker #(.DEPTH(DEPTH)) u_deq_checker (.*);
